// File: design/dtsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tracker helpers for the dual-tracker sync deframer.
// No dependencies.
package dtsd_pkg;

  localparam int          CHUNK_SIZE   = 16;
  localparam logic [7:0]  PRESYNC_CODE = 8'hFF;
  localparam int          CFG_DATA_W   = 16;

  typedef enum logic [2:0] {
    ST_CONTINUE  = 3'd0,
    ST_GOOD      = 3'd1,
    ST_CORRUPT   = 3'd2,
    ST_SYNC_ERR  = 3'd3,
    ST_LINK_FAIL = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_MAX_LENGTH  = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] conf;
  } tracker_t;

  typedef struct packed {
    tracker_t lead;
    tracker_t other;
  } tracker_pair_t;

  typedef struct packed {
    tracker_pair_t pair;
    logic          sync_err;
    logic          done;
  } track_res_t;

  function automatic tracker_t lower_conf(tracker_t t);
    tracker_t r;
    r = t;
    if (t.conf == 8'd0) r.val = PRESYNC_CODE;
    else r.conf = t.conf - 8'd1;
    return r;
  endfunction

  function automatic logic [7:0] raise_conf(logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  function automatic logic [7:0] tick_value(logic [7:0] v);
    return (v == PRESYNC_CODE) ? v : v - 8'd1;
  endfunction

endpackage

// File: design/dual_tracker_sync_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the dual-tracker sync deframer: input register, chunk update, result register.
// Depends on dtsd_pkg, dtsd_tracker and dtsd_count.

// One chunk report in, one result out. A report sits in the input register while
// the tracker pair and byte total update, then lands in the result register; one
// chunk per cycle is taken unless the result register stalls. State feedback (trackers,
// total, failure run) closes within a single stage. Every end status (done,
// sync error, link failure) returns the state to reset. Configuration (index 0
// max_length, index 1 retry_limit) must be written while idle; the block does not enforce it.
module dual_tracker_sync_deframer_top #(
  parameter int TOTAL_WIDTH = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     read_failed_i,
  input  logic [7:0]               sync_code_i,
  input  logic [3:0]               data_count_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output dtsd_pkg::status_e        status_o,
  output logic                     store_data_o,
  output logic [19:0]              total_bytes_o
);
  import dtsd_pkg::*;

  localparam int ExtW = (TOTAL_WIDTH > 20) ? TOTAL_WIDTH : 20;

  // configuration
  logic [15:0] max_length_q;
  logic [3:0]  retry_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q  <= 16'hFFFF;
      retry_limit_q <= 4'd10;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_LENGTH:  max_length_q  <= cfg_data_i;
        REG_RETRY_LIMIT: retry_limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_vld_q, in_vld_d;
  logic       failed_q;
  logic [7:0] code_q;
  logic [3:0] count_q;
  logic       adv, in_load, process;
  logic       out_vld_q, out_vld_d;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !adv;
  assign in_load    = in_valid_i && !in_stall_o;
  assign process    = in_vld_q && adv;

  always_comb begin
    if (in_load) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    else in_vld_d = in_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      failed_q <= read_failed_i;
      code_q   <= sync_code_i;
      count_q  <= data_count_i;
    end
  end

  // deframer state
  tracker_pair_t          pair_q, pair_d;
  logic [TOTAL_WIDTH-1:0] btotal_q, btotal_d;
  logic                   corrupt_q, corrupt_d;
  logic [3:0]             fail_run_q, fail_run_d;

  track_res_t             trk;
  logic [TOTAL_WIDTH-1:0] sum_total;
  logic                   too_long;

  dtsd_tracker u_tracker (
    .pair_i      (pair_q),
    .sync_code_i (code_q),
    .res_o       (trk)
  );

  dtsd_count #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_count (
    .total_i      (btotal_q),
    .data_count_i (count_q),
    .max_length_i (max_length_q),
    .total_o      (sum_total),
    .too_long_o   (too_long)
  );

  logic [3:0]             limit, fail_inc;
  status_e                status_d;
  logic                   store_d;
  logic [TOTAL_WIDTH-1:0] res_total;
  logic [ExtW-1:0]        res_total_x;
  logic                   clear;
  tracker_pair_t          pair_rst;

  assign limit    = (retry_limit_q == 4'd0) ? 4'd1 : retry_limit_q;
  assign fail_inc = (fail_run_q == 4'hF) ? fail_run_q : fail_run_q + 4'd1;
  assign pair_rst = '{lead: '{val: PRESYNC_CODE, conf: 8'd0},
                      other: '{val: PRESYNC_CODE, conf: 8'd0}};

  always_comb begin
    status_d   = ST_CONTINUE;
    store_d    = 1'b0;
    res_total  = btotal_q;
    pair_d     = pair_q;
    btotal_d   = btotal_q;
    corrupt_d  = corrupt_q;
    fail_run_d = fail_run_q;
    if (failed_q) begin
      corrupt_d  = 1'b1;
      fail_run_d = fail_inc;
      if (fail_inc >= limit) status_d = ST_LINK_FAIL;
    end else begin
      fail_run_d = 4'd0;
      btotal_d   = sum_total;
      res_total  = sum_total;
      corrupt_d  = corrupt_q | too_long;
      store_d    = !too_long;
      pair_d     = trk.pair;
      if (trk.sync_err) status_d = ST_SYNC_ERR;
      else if (trk.done) status_d = corrupt_d ? ST_CORRUPT : ST_GOOD;
    end
    clear = (status_d != ST_CONTINUE);
    if (clear) begin
      pair_d     = pair_rst;
      btotal_d   = '0;
      corrupt_d  = 1'b0;
      fail_run_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q     <= '{lead: '{val: PRESYNC_CODE, conf: 8'd0},
                      other: '{val: PRESYNC_CODE, conf: 8'd0}};
      btotal_q   <= '0;
      corrupt_q  <= 1'b0;
      fail_run_q <= 4'd0;
    end else if (process) begin
      pair_q     <= pair_d;
      btotal_q   <= btotal_d;
      corrupt_q  <= corrupt_d;
      fail_run_q <= fail_run_d;
    end
  end

  // result register
  status_e     status_q;
  logic        store_q;
  logic [19:0] total_q;

  assign res_total_x = ExtW'(res_total);

  always_comb begin
    if (process) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      status_q <= status_d;
      store_q  <= store_d;
      total_q  <= res_total_x[19:0];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign store_data_o  = store_q;
  assign total_bytes_o = total_q;

  // checks
  a_lead_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_q.lead.conf >= pair_q.other.conf)
    else $error("tracker order lost: other tracker more confident than lead");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && clear) |=> (btotal_q == '0 && !corrupt_q && fail_run_q == 4'd0 &&
                            pair_q.lead.conf == 8'd0))
    else $error("state not returned to reset after end status");

  a_link_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q == ST_LINK_FAIL) |-> !store_q)
    else $error("link failure result marks data for storing");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i && in_vld_q))
    else $error("input stalled while the result register is free");

endmodule

// File: design/dtsd_tracker.sv
`timescale 1ns / 1ps
// Sync tracker pair update for one chunk: match, adopt, lower, reorder, tick.
// Depends on dtsd_pkg.
module dtsd_tracker (
  input  dtsd_pkg::tracker_pair_t pair_i,
  input  logic [7:0]              sync_code_i,
  output dtsd_pkg::track_res_t    res_o
);
  import dtsd_pkg::*;

  tracker_t lead_m, other_m;
  logic     lead_hit, other_hit, sync_err;
  tracker_t lead_s, other_s;

  assign lead_hit  = (pair_i.lead.conf == 8'd0) || (pair_i.lead.val == sync_code_i);
  assign other_hit = (pair_i.other.conf == 8'd0) || (pair_i.other.val == sync_code_i);

  always_comb begin
    lead_m   = pair_i.lead;
    other_m  = pair_i.other;
    sync_err = 1'b0;
    if (sync_code_i == PRESYNC_CODE) begin
      lead_m  = lower_conf(pair_i.lead);
      other_m = lower_conf(pair_i.other);
    end else if (lead_hit) begin
      // the lead tracker, if unclaimed or matching, takes the code (lead has priority)
      lead_m.val  = sync_code_i;
      lead_m.conf = raise_conf(pair_i.lead.conf);
      other_m     = lower_conf(pair_i.other);
    end else if (other_hit) begin
      other_m.val  = sync_code_i;
      other_m.conf = raise_conf(pair_i.other.conf);
      lead_m       = lower_conf(pair_i.lead);
    end else begin
      sync_err = 1'b1;
    end
  end

  // keep the more confident tracker in the lead slot
  always_comb begin
    if (other_m.conf > lead_m.conf) begin
      lead_s  = other_m;
      other_s = lead_m;
    end else begin
      lead_s  = lead_m;
      other_s = other_m;
    end
  end

  always_comb begin
    res_o.sync_err = sync_err;
    res_o.done     = !sync_err && (lead_s.val == 8'd0) && (lead_s.conf != 8'd0);
    res_o.pair.lead  = lead_s;
    res_o.pair.other = other_s;
    if (!res_o.done) begin
      res_o.pair.lead.val  = tick_value(lead_s.val);
      res_o.pair.other.val = tick_value(other_s.val);
    end
  end

endmodule

// File: design/dtsd_count.sv
`timescale 1ns / 1ps
// Saturating data byte total and message length check for one chunk.
// Depends on dtsd_pkg.
module dtsd_count #(
  parameter int TOTAL_WIDTH = 20
) (
  input  logic [TOTAL_WIDTH-1:0] total_i,
  input  logic [3:0]             data_count_i,
  input  logic [15:0]            max_length_i,
  output logic [TOTAL_WIDTH-1:0] total_o,
  output logic                   too_long_o
);
  import dtsd_pkg::*;

  localparam int ClampMax = (CHUNK_SIZE - 1 > 15) ? 15 : CHUNK_SIZE - 1;
  localparam int CmpW     = (TOTAL_WIDTH > 16) ? TOTAL_WIDTH : 16;

  logic [3:0]             count_c;
  logic [TOTAL_WIDTH:0]   sum;
  logic [CmpW-1:0]        total_x, max_x;

  assign count_c = (data_count_i > 4'(ClampMax)) ? 4'(ClampMax) : data_count_i;
  assign sum     = {1'b0, total_i} + (TOTAL_WIDTH + 1)'(count_c);
  // carry out means the total would pass the all-ones ceiling
  assign total_o = sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : sum[TOTAL_WIDTH-1:0];

  assign total_x    = CmpW'(total_o);
  assign max_x      = CmpW'(max_length_i);
  assign too_long_o = total_x > max_x;

endmodule
